/* rtl/itrd_pkg.sv */
// Shared constants and types for the integer to radix digits converter.
package itrd_pkg;

   localparam int NUM_W        = 32;
   localparam int CHAR_W       = 8;
   localparam int ALPHA_REGS   = 8;
   localparam int ALPHA_REG_W  = 64;
   localparam int ALPHA_SLOTS  = 64;
   localparam int ALPHA_W      = ALPHA_REGS * ALPHA_REG_W;
   localparam int SLOT_IDX_W   = $clog2(ALPHA_SLOTS);
   localparam int CSR_INDEX_W  = $clog2(ALPHA_REGS);
   localparam int SEEN_W       = 2 ** (CHAR_W - 1);
   localparam int MAX_DIGITS   = 32;
   localparam int FIFO_DEPTH   = 2;
   localparam int DEF_MAX_BASE = 64;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

   // One queued conversion: sign and unsigned magnitude.
   typedef struct packed {
      logic             neg;
      logic [NUM_W-1:0] mag;
   } item_type;

endpackage

/* rtl/itrd_front.sv */
// Front end: alphabet registers, alphabet check and request classification.
module itrd_front import itrd_pkg::*; #(
   parameter int MAX_BASE = DEF_MAX_BASE,
   localparam int BASE_W = $clog2(MAX_BASE + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ALPHA_REG_W-1:0] csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [NUM_W-1:0]       req_tdata,
   output logic                   push_valid,
   input  logic                   push_ready,
   output item_type               push_item,
   output logic [ALPHA_W-1:0]     alpha_flat,
   output logic [BASE_W-1:0]      base
);

   typedef enum logic [0:0] {ST_READY, ST_SCAN} state_type;

   state_type              state_ff, state_in;
   logic [ALPHA_REG_W-1:0] alpha_ff [ALPHA_REGS];
   logic [ALPHA_REG_W-1:0] alpha_in [ALPHA_REGS];
   logic [BASE_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [SEEN_W-1:0]      seen_ff, seen_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic                   alpha_ok_ff, alpha_ok_in;

   logic [SLOT_IDX_W-1:0]  scan_pos;
   logic [CHAR_W-1:0]      scan_char;
   logic                   at_end;
   logic                   bad_char;

   always_comb begin
      for (int r = 0; r < ALPHA_REGS; r++) begin
         alpha_flat[r*ALPHA_REG_W +: ALPHA_REG_W] = alpha_ff[r];
      end
   end

   assign scan_pos  = SLOT_IDX_W'(scan_idx_ff);
   assign scan_char = alpha_flat[{scan_pos, 3'b000} +: CHAR_W];
   assign at_end    = (scan_idx_ff == BASE_W'(MAX_BASE)) || (scan_char == CHAR_NUL);
   assign bad_char  = (scan_char < CHAR_SPACE) || (scan_char >= CHAR_DEL) ||
                      (scan_char == CHAR_PLUS) || (scan_char == CHAR_MINUS) ||
                      seen_ff[scan_char[CHAR_W-2:0]];

   // The scan walks the alphabet one character a cycle, marking each in a
   // seen map, so that duplicates are found without pairwise comparison.
   always_comb begin
      state_in    = state_ff;
      alpha_in    = alpha_ff;
      scan_idx_in = scan_idx_ff;
      seen_in     = seen_ff;
      base_in     = base_ff;
      alpha_ok_in = alpha_ok_ff;
      if (csr_valid) begin
         alpha_in[csr_index] = csr_data;
         state_in            = ST_SCAN;
         scan_idx_in         = '0;
         seen_in             = '0;
         alpha_ok_in         = 1'b0;
      end else begin
         case (state_ff)
            ST_SCAN: begin
               if (at_end) begin
                  base_in     = scan_idx_ff;
                  alpha_ok_in = (scan_idx_ff >= BASE_W'(2));
                  state_in    = ST_READY;
               end else if (bad_char) begin
                  alpha_ok_in = 1'b0;
                  state_in    = ST_READY;
               end else begin
                  seen_in[scan_char[CHAR_W-2:0]] = 1'b1;
                  scan_idx_in = scan_idx_ff + BASE_W'(1);
               end
            end
            ST_READY: begin
            end
            default: begin
               state_in = ST_READY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_READY;
         alpha_ff    <= '{default: '0};
         scan_idx_ff <= '0;
         seen_ff     <= '0;
         base_ff     <= '0;
         alpha_ok_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         alpha_ff    <= alpha_in;
         scan_idx_ff <= scan_idx_in;
         seen_ff     <= seen_in;
         base_ff     <= base_in;
         alpha_ok_ff <= alpha_ok_in;
      end
   end

   assign csr_ready  = 1'b1;
   // With an invalid alphabet requests are taken and dropped.
   assign req_tready = (state_ff == ST_READY) && (!alpha_ok_ff || push_ready);
   assign push_valid = req_tvalid && req_tready && alpha_ok_ff;

   assign push_item.neg = req_tdata[NUM_W-1];
   assign push_item.mag = req_tdata[NUM_W-1] ? (NUM_W'(0) - req_tdata) : req_tdata;

   assign base = base_ff;

endmodule

/* rtl/itrd_fifo.sv */
// Short queue of pending conversions between the front and back ends.
module itrd_fifo import itrd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   item_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign in_ready  = (count_ff != CNT_W'(FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* rtl/itrd_back.sv */
// Back end: bit-serial divider, digit stack and character output register.
module itrd_back import itrd_pkg::*; #(
   parameter int MAX_BASE = DEF_MAX_BASE,
   localparam int BASE_W = $clog2(MAX_BASE + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  item_type           pop_item,
   input  logic [ALPHA_W-1:0] alpha_flat,
   input  logic [BASE_W-1:0]  base,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [CHAR_W-1:0]  rsp_tdata,
   output logic               rsp_tlast
);

   localparam int DIG_W     = $clog2(MAX_BASE);
   localparam int TRIAL_W   = DIG_W + 1;
   localparam int BIT_CNT_W = $clog2(NUM_W);
   localparam int NDIG_W    = $clog2(MAX_DIGITS + 1);
   localparam int STACK_W   = $clog2(MAX_DIGITS);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_SIGN, ST_EMIT} state_type;

   state_type             state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [NUM_W-1:0]      quot_ff, quot_in;
   logic [DIG_W-1:0]      rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [NDIG_W-1:0]     ndig_ff, ndig_in;
   logic [DIG_W-1:0]      stack_ff [MAX_DIGITS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [TRIAL_W-1:0]    trial;
   logic [TRIAL_W-1:0]    divisor;
   logic                  trial_ge;
   logic [DIG_W-1:0]      rem_step;
   logic [NUM_W-1:0]      quot_step;
   logic                  last_bit;
   logic                  push_digit;
   logic                  out_free;
   logic [STACK_W-1:0]    rd_idx;
   logic [SLOT_IDX_W-1:0] char_pos;
   logic [CHAR_W-1:0]     digit_char;

   // One quotient bit a cycle: restoring division by the alphabet length.
   assign divisor   = TRIAL_W'(base);
   assign trial     = {rem_ff, quot_ff[NUM_W-1]};
   assign trial_ge  = (trial >= divisor);
   assign rem_step  = trial_ge ? DIG_W'(trial - divisor) : DIG_W'(trial);
   assign quot_step = {quot_ff[NUM_W-2:0], trial_ge};
   assign last_bit  = (bit_cnt_ff == BIT_CNT_W'(NUM_W - 1));
   assign push_digit = (state_ff == ST_DIVIDE) && last_bit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_idx     = STACK_W'(ndig_ff - NDIG_W'(1));
   assign char_pos   = SLOT_IDX_W'(stack_ff[rd_idx]);
   assign digit_char = alpha_flat[{char_pos, 3'b000} +: CHAR_W];

   assign pop_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      ndig_in      = ndig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               neg_in     = pop_item.neg;
               quot_in    = pop_item.mag;
               rem_in     = '0;
               bit_cnt_in = '0;
               ndig_in    = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quot_in    = quot_step;
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (last_bit) begin
               ndig_in    = ndig_ff + NDIG_W'(1);
               rem_in     = '0;
               bit_cnt_in = '0;
               if ((quot_step == '0) || (ndig_ff >= NDIG_W'(MAX_DIGITS - 1))) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = digit_char;
               rsp_last_in  = (ndig_ff == NDIG_W'(1));
               ndig_in      = ndig_ff - NDIG_W'(1);
               if (ndig_ff == NDIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      ndig_ff     <= ndig_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digits come out least significant first and are stacked for reversal.
   always_ff @(posedge clock) begin
      if (push_digit) begin
         stack_ff[STACK_W'(ndig_ff)] <= rem_step;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/int_to_radix_digits_core.sv */
// Top level of the integer to radix digits converter.
// Each request carries one signed 32-bit number; the block answers with its
// text in the radix given by the configured alphabet: a '-' for negative
// values, then the digits from the most significant down, tlast on the final
// character. The alphabet is written through the csr port as eight 64-bit
// words; its length is the position of its first zero byte, capped at
// MAX_BASE. An alphabet shorter than two characters, or holding '+', '-', a
// byte outside 32..126 or a repeated character, is invalid, and requests are
// then taken and dropped without any response. After every csr write the
// alphabet is scanned one character a cycle, and requests are held off
// meanwhile. Each digit is worked out on the single bit-serial restoring
// divider and then sent out; a two-entry queue lets the next request be
// taken while one is being converted.
module int_to_radix_digits_core import itrd_pkg::*; #(
   parameter int MAX_BASE = DEF_MAX_BASE
) (
   input  logic                   clock,
   input  logic                   reset,
   // csr port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ALPHA_REG_W-1:0] csr_data,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [NUM_W-1:0]       req_tdata,   // [31:0] number
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CHAR_W-1:0]      rsp_tdata,   // [7:0] char_code
   output logic                   rsp_tlast
);

   localparam int BASE_W = $clog2(MAX_BASE + 1);

   logic               push_valid, push_ready;
   item_type           push_item;
   logic               pop_valid, pop_ready;
   item_type           pop_item;
   logic [ALPHA_W-1:0] alpha_flat;
   logic [BASE_W-1:0]  base;

   itrd_front #(.MAX_BASE(MAX_BASE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .alpha_flat (alpha_flat),
      .base       (base)
   );

   itrd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_item  (pop_item)
   );

   itrd_back #(.MAX_BASE(MAX_BASE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .alpha_flat (alpha_flat),
      .base       (base),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/itrd_checker.sv */
// Port-level checks for the integer to radix digits converter.
module itrd_checker import itrd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [CHAR_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // A response that is not taken holds its character and end flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // A csr write starts an alphabet scan, which holds requests off.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("request taken while the alphabet is being checked");

   // The csr port never pushes back.
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port stalled");

endmodule

bind int_to_radix_digits_core itrd_checker u_checker (.*);
